[sv/circle_box_pushout_resolver_core_defines.svh]
// Assertion macros for the circle-box push-out resolver.
// Define ASSERT_OFF to compile the checks out.
`ifndef CIRCLE_BOX_PUSHOUT_RESOLVER_CORE_DEFINES_SVH
`define CIRCLE_BOX_PUSHOUT_RESOLVER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CBPR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CBPR_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBPR_ASSERT(label, clk, rst, prop, msg)
`define CBPR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/cbpr_pkg.sv]
// Shared types and constants for the circle-box push-out resolver.
// No dependencies.
`timescale 1ns / 1ps
package cbpr_pkg;
  localparam int MaxBoxes = 16;
  localparam int IdxW = $clog2(MaxBoxes);
  localparam int CntW = $clog2(MaxBoxes + 1);

  localparam logic [1:0] AddrRadius = 2'd0;
  localparam logic [1:0] AddrBound  = 2'd1;
  localparam logic [1:0] AddrPasses = 2'd2;
  localparam logic [1:0] AddrActive = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DIST, ST_SQRT, ST_PUSH, ST_DIVX, ST_DIVZ, ST_APPLY, ST_NEXT,
    ST_CLAMP, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [35:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [35:0] quo;
  } div_rsp_t;
endpackage

[sv/cbpr_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on cbpr_pkg.
`timescale 1ns / 1ps
module cbpr_divider (
  input  logic              clk,
  input  logic              rst,
  input  cbpr_pkg::div_req_t req,
  output cbpr_pkg::div_rsp_t rsp
);
  import cbpr_pkg::*;
  logic [35:0] quo;
  logic [16:0] rem;
  logic [15:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;

  always_comb begin
    trial = {rem[15:0], quo[35]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd36;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quo <= {quo[34:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[34:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quo};
endmodule

[sv/circle_box_pushout_resolver_core.sv]
// Circle-box push-out resolver: box table in synchronous RAM, sequential resolve.
// A resolve steps each of n boxes (n = active_boxes capped at 16) through read, distance,
// push and next states on each of pass_count passes, then clamps and presents its result.
// Each hit adds a square root and two divisions in a shared serial divider; a hit at zero
// distance skips the divisions. One item is taken at a time. Reset (synchronous, active high)
// restores the register defaults and idles the sequencer; the box RAM is not cleared.
`timescale 1ns / 1ps
`include "circle_box_pushout_resolver_core_defines.svh"
module circle_box_pushout_resolver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [3:0]  box_index,
  input  logic signed [15:0] min_x,
  input  logic signed [15:0] min_z,
  input  logic signed [15:0] max_x,
  input  logic signed [15:0] max_y,
  input  logic signed [15:0] max_z,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] new_x,
  output logic signed [15:0] new_z,
  output logic        hit_any
);
  import cbpr_pkg::*;

  logic [11:0] collision_radius;
  logic [14:0] world_bound;
  logic [2:0]  pass_count;
  logic [4:0]  active_boxes;

  // Box RAM: one 80-bit word per slot.
  logic [79:0] box_mem [MaxBoxes];
  logic [79:0] rd_word;

  state_t state, state_next;
  logic signed [15:0] px, pz, py;
  logic [2:0]  pass;
  logic [IdxW:0] bidx;
  logic [CntW-1:0] nbox;
  logic        hit;
  logic signed [16:0] dx, dz;
  logic [33:0] dsq;
  logic [33:0] sq_rem;
  logic [16:0] sq_res;
  logic [4:0]  sq_cnt;
  logic signed [17:0] ov;
  logic signed [35:0] push_x, push_z;
  div_req_t dreq;
  div_rsp_t drsp;

  assign pready = 1'b1;
  assign in_ready = (state == ST_IDLE) && !rst;

  wire cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      collision_radius <= 12'd358;
      world_bound <= 15'd11264;
      pass_count <= 3'd3;
      active_boxes <= 5'd16;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        AddrRadius: collision_radius <= pwdata[11:0];
        AddrBound:  world_bound <= pwdata[14:0];
        AddrPasses: pass_count <= pwdata[2:0];
        AddrActive: active_boxes <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      AddrRadius: prdata = {20'd0, collision_radius};
      AddrBound:  prdata = {17'd0, world_bound};
      AddrPasses: prdata = {29'd0, pass_count};
      AddrActive: prdata = {27'd0, active_boxes};
    endcase
  end

  wire in_xfer = in_valid && in_ready;
  always_ff @(posedge clk) begin
    if (in_xfer && !req_type) begin
      box_mem[box_index[IdxW-1:0]] <= {min_x, min_z, max_x, max_y, max_z};
    end
    rd_word <= box_mem[bidx[IdxW-1:0]];
  end

  logic signed [15:0] lo_x, lo_z, hi_x, hi_y, hi_z, cx, cz;
  assign {lo_x, lo_z, hi_x, hi_y, hi_z} = rd_word;
  always_comb begin
    if (px < lo_x) cx = lo_x;
    else if (px > hi_x) cx = hi_x;
    else cx = px;
    if (pz < lo_z) cz = lo_z;
    else if (pz > hi_z) cz = hi_z;
    else cz = pz;
  end

  wire [23:0] rsq = collision_radius * collision_radius;
  wire last_box = (bidx + {{IdxW{1'b0}}, 1'b1}) >= nbox;
  wire last_pass = (pass + 3'd1) >= pass_count;
  wire [CntW-1:0] nbox_in = (active_boxes > 5'(MaxBoxes)) ? CntW'(MaxBoxes)
                                                          : active_boxes[CntW-1:0];
  wire [16:0] adx = dx[16] ? 17'(-dx) : 17'(dx);
  wire [16:0] adz = dz[16] ? 17'(-dz) : 17'(dz);

  always_comb dsq = adx * adx + adz * adz;
  always_comb ov = 18'(collision_radius) - 18'(sq_res);

  // Square root: classic digit-by-digit, one result bit per cycle.
  wire [33:0] sq_bit = 34'd1 << {sq_cnt - 5'd1, 1'b0};
  logic [33:0] sq_cmp;
  always_comb sq_cmp = ({17'd0, sq_res} << sq_cnt) + sq_bit;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer && req_type) state_next = (pass_count == 3'd0 || nbox_in == '0)
                  ? ST_CLAMP : ST_READ;
      ST_READ:  state_next = ST_DIST;
      ST_DIST:  state_next = ST_PUSH;
      ST_PUSH:  state_next = (dsq < {10'd0, rsq} && py < hi_y) ? ST_SQRT : ST_NEXT;
      // A zero-distance hit skips the divider and goes straight to apply.
      ST_SQRT:  if (sq_cnt == 5'd0) state_next = (sq_res == 17'd0) ? ST_APPLY : ST_DIVX;
      ST_DIVX:  if (drsp.done) state_next = ST_DIVZ;
      ST_DIVZ:  if (drsp.done) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_NEXT;
      ST_NEXT:  state_next = (last_box && last_pass) ? ST_CLAMP : ST_READ;
      ST_CLAMP: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  wire [33:0] prod_x = adx * ov[16:0];
  wire [33:0] prod_z = adz * ov[16:0];

  always_comb begin
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = sq_res[15:0];
    if (state == ST_SQRT && sq_cnt == 5'd0 && sq_res != 17'd0) begin
      dreq.start = 1'b1;
      dreq.num = {2'd0, prod_x};
    end else if (state == ST_DIVX && drsp.done) begin
      dreq.start = 1'b1;
      dreq.num = {2'd0, prod_z};
    end
  end

  cbpr_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [17:0] sum_x, sum_z;
  always_comb begin
    sum_x = 18'(px) + 18'(push_x);
    sum_z = 18'(pz) + 18'(push_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= (state_next == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_xfer && req_type) begin
        px <= pos_x; py <= pos_y; pz <= pos_z;
        pass <= '0; bidx <= '0; hit <= 1'b0; nbox <= nbox_in;
      end
      ST_DIST: begin
        dx <= 17'(px) - 17'(cx);
        dz <= 17'(pz) - 17'(cz);
      end
      ST_PUSH: begin
        sq_rem <= dsq;
        sq_res <= '0;
        sq_cnt <= 5'd16;
      end
      ST_SQRT: begin
        if (sq_cnt != 5'd0) begin
          if (sq_rem >= sq_cmp) begin
            sq_rem <= sq_rem - sq_cmp;
            sq_res <= sq_res + (17'd1 << (sq_cnt - 5'd1));
          end
          sq_cnt <= sq_cnt - 5'd1;
        end else begin
          hit <= 1'b1;
          if (sq_res == 17'd0) begin
            push_x <= 36'(collision_radius);
            push_z <= '0;
          end
        end
      end
      ST_DIVX: if (drsp.done) push_x <= dx[16] ? -$signed(drsp.quo) : $signed(drsp.quo);
      ST_DIVZ: if (drsp.done) push_z <= dz[16] ? -$signed(drsp.quo) : $signed(drsp.quo);
      ST_APPLY: begin
        px <= (sum_x > 18'sd32767) ? 16'sh7fff : (sum_x < -18'sd32768) ? 16'sh8000
              : sum_x[15:0];
        pz <= (sum_z > 18'sd32767) ? 16'sh7fff : (sum_z < -18'sd32768) ? 16'sh8000
              : sum_z[15:0];
      end
      ST_NEXT: begin
        if (last_box) begin
          bidx <= '0;
          pass <= pass + 3'd1;
        end else begin
          bidx <= bidx + {{IdxW{1'b0}}, 1'b1};
        end
      end
      ST_CLAMP: begin
        if (px > $signed({1'b0, world_bound})) new_x <= $signed({1'b0, world_bound});
        else if (px < -$signed({1'b0, world_bound})) new_x <= -$signed({1'b0, world_bound});
        else new_x <= px;
        if (pz > $signed({1'b0, world_bound})) new_z <= $signed({1'b0, world_bound});
        else if (pz < -$signed({1'b0, world_bound})) new_z <= -$signed({1'b0, world_bound});
        else new_z <= pz;
        hit_any <= hit;
      end
      default: ;
    endcase
  end

  `CBPR_ASSERT(a_out_only_in_out, clk, rst, out_valid |-> state == ST_OUT, "stray out_valid")
  `CBPR_ASSERT(a_no_accept_busy, clk, rst, (state != ST_IDLE) |-> !in_ready, "ready while busy")
  `CBPR_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> out_valid && $stable(new_x), "result dropped")
endmodule
